[hw/rtl/ihp_pkg.sv]
// ----------------------------------------------------------------------------
// Intel HEX record parser package
// Shared constants, result codes and the command and status groups that
// pass between the parser controller and its datapath.
// ----------------------------------------------------------------------------
package ihp_pkg;

    localparam int MAX_DATA_BYTES  = 32;
    localparam int MAX_LINE_CHARS  = 599;
    localparam int MIN_LINE_CHARS  = 11;
    localparam int CNT_W           = 10;
    localparam int IDX_W           = $clog2(MAX_DATA_BYTES);

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_COLON  = 3'd1;
    localparam logic [2:0] ERR_SHORT     = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_SEGMENT = 8'h02;
    localparam logic [7:0] REC_LINEAR  = 8'h04;

    typedef struct packed {
        logic take_char;
        logic clear_count;
        logic cap_base;
        logic idx_clear;
        logic idx_inc;
        logic load_single;
        logic load_overlong;
        logic load_byte;
        logic set_base;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       is_term;
        logic       cnt_zero;
        logic       overlong;
        logic       line_err;
        logic [7:0] rec_type;
        logic       n_zero;
        logic       idx_last;
        logic       out_free;
    } dp_status_t;

    function automatic logic [3:0] nib_of(input logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            r = 4'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            r = 4'(c - CHAR_UPPER_A + 8'd10);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            r = 4'(c - CHAR_LOWER_A + 8'd10);
        end
        return r;
    endfunction

endpackage

[hw/rtl/ihp_if.sv]
// ----------------------------------------------------------------------------
// Intel HEX record parser channels
// Valid and ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
interface ihp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ihp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        last;

    modport source (output valid, output kind, output error_code, output data_byte,
                    output byte_address, output last, input ready);
    modport sink   (input valid, input kind, input error_code, input data_byte,
                    input byte_address, input last, output ready);
endinterface

[hw/rtl/intel_hex_record_parser_unit.sv]
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Parses Intel HEX text into data bytes with absolute addresses, end of
// file markers and bad line reports.
// ----------------------------------------------------------------------------
// The character channel takes one ASCII character per request. While a line
// is being collected a character is taken every cycle. A CR or LF that ends
// a non-empty line holds the channel off while the record is checked and
// the bases are updated.
// A data record then gives its bytes on the result channel one at a time,
// each through the registered read of the line buffer in S_RD and then the
// output register in S_WR; characters are taken again once the last byte
// is loaded. End of file, empty data records and bad lines give a single
// result, loaded in S_END after the terminator; an overlong line gives its
// error from S_OVER after the dropped character.
// The output register holds a result until it is taken; while the receiver
// stalls, collection goes on until a result must be loaded.
// Reset clears the bases, the line state and the output valid; the line
// buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    ihp_char_if.sink      char_ch,
    ihp_result_if.source  result_ch
);
    import ihp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    ihp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(char_ch.valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ihp_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_ch.char_in),
        .cmd      (cmd),
        .status   (status),
        .result_ch(result_ch)
    );

    assign char_ch.ready = in_ready;

endmodule

[hw/rtl/ihp_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ihp_datapath.sv]
// ----------------------------------------------------------------------------
// Intel HEX record parser datapath
// Line collection registers, record checks, base registers, the data byte
// buffer and the result output register.
// ----------------------------------------------------------------------------
module ihp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         char_in,
    input  ihp_pkg::ctrl_cmd_t cmd,
    output ihp_pkg::dp_status_t status,
    ihp_result_if.source       result_ch
);
    import ihp_pkg::*;

    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic             colon_seen_reg, colon_seen_next;
    logic [3:0]       nibble_hold_reg, nibble_hold_next;
    logic [31:0]      header_bytes_reg, header_bytes_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [7:0]       checksum_byte_reg, checksum_byte_next;
    logic [15:0]      linear_base_reg, linear_base_next;
    logic [15:0]      segment_base_reg, segment_base_next;
    logic [7:0]       byte0_reg, byte0_next;
    logic [7:0]       byte1_reg, byte1_next;
    logic [31:0]      base_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [2:0]       err_reg, err_next;
    logic [7:0]       data_reg, data_next;
    logic [31:0]      addr_reg, addr_next;
    logic             last_reg, last_next;

    logic [7:0]       byte_val;
    logic [CNT_W-2:0] k_idx;
    logic [CNT_W-2:0] j_idx;
    logic [7:0]       rec_count;
    logic [7:0]       rec_type;
    logic [2:0]       line_err;
    logic [31:0]      base_comb;
    logic             is_term;
    logic             overlong;
    logic             out_free;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic [7:0]       base_hi;
    logic [7:0]       base_lo;

    assign rec_count = header_bytes_reg[31:24];
    assign rec_type  = header_bytes_reg[7:0];
    assign byte_val  = {nibble_hold_reg, nib_of(char_in)};
    assign k_idx     = char_count_reg[CNT_W-1:1] - (CNT_W-1)'(1);
    assign j_idx     = k_idx - (CNT_W-1)'(4);
    assign is_term   = (char_in == CHAR_LF) || (char_in == CHAR_CR);
    assign overlong  = char_count_reg >= CNT_W'(MAX_LINE_CHARS);
    assign out_free  = !out_valid_reg || result_ch.ready;
    assign base_hi   = (rec_count > 8'd0) ? byte0_reg : 8'd0;
    assign base_lo   = (rec_count > 8'd1) ? byte1_reg : 8'd0;

    assign base_comb = {16'd0, header_bytes_reg[23:8]} + {linear_base_reg, 16'd0}
                     + {12'd0, segment_base_reg, 4'd0};

    always_comb
    begin
        if (!colon_seen_reg)
        begin
            line_err = ERR_NO_COLON;
        end
        else if (char_count_reg < CNT_W'(MIN_LINE_CHARS))
        begin
            line_err = ERR_SHORT;
        end
        else if (rec_count > 8'(MAX_DATA_BYTES))
        begin
            line_err = ERR_TOO_LONG;
        end
        else if (char_count_reg < CNT_W'(MIN_LINE_CHARS) + CNT_W'({rec_count, 1'b0}))
        begin
            line_err = ERR_SHORT;
        end
        else if (8'(8'd0 - running_sum_reg) != checksum_byte_reg)
        begin
            line_err = ERR_CHECKSUM;
        end
        else
        begin
            line_err = ERR_NONE;
        end
    end

    always_comb
    begin
        char_count_next    = char_count_reg;
        colon_seen_next    = colon_seen_reg;
        nibble_hold_next   = nibble_hold_reg;
        header_bytes_next  = header_bytes_reg;
        running_sum_next   = running_sum_reg;
        checksum_byte_next = checksum_byte_reg;
        byte0_next         = byte0_reg;
        byte1_next         = byte1_reg;
        ram_we             = 1'b0;
        if (cmd.take_char && !is_term)
        begin
            if (overlong)
            begin
                char_count_next = '0;
            end
            else
            begin
                if (char_count_reg == '0)
                begin
                    colon_seen_next    = (char_in == CHAR_COLON);
                    running_sum_next   = 8'd0;
                    header_bytes_next  = 32'd0;
                    checksum_byte_next = 8'd0;
                end
                else if (char_count_reg[0])
                begin
                    nibble_hold_next = nib_of(char_in);
                end
                else if (k_idx < (CNT_W-1)'(4))
                begin
                    header_bytes_next = (k_idx == '0) ? {24'd0, byte_val}
                                                      : {header_bytes_reg[23:0], byte_val};
                    running_sum_next  = running_sum_reg + byte_val;
                end
                else if (j_idx < (CNT_W-1)'(rec_count))
                begin
                    running_sum_next = running_sum_reg + byte_val;
                    ram_we           = j_idx < (CNT_W-1)'(MAX_DATA_BYTES);
                    if (j_idx == '0)
                    begin
                        byte0_next = byte_val;
                    end
                    if (j_idx == (CNT_W-1)'(1))
                    begin
                        byte1_next = byte_val;
                    end
                end
                else if (j_idx == (CNT_W-1)'(rec_count))
                begin
                    checksum_byte_next = byte_val;
                end
                char_count_next = char_count_reg + CNT_W'(1);
            end
        end
        if (cmd.clear_count)
        begin
            char_count_next = '0;
        end
    end

    always_comb
    begin
        linear_base_next  = linear_base_reg;
        segment_base_next = segment_base_reg;
        if (cmd.set_base)
        begin
            if (rec_type == REC_LINEAR)
            begin
                linear_base_next = {base_hi, base_lo};
            end
            if (rec_type == REC_SEGMENT)
            begin
                segment_base_next = {base_hi, base_lo};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ch.ready;
        kind_next      = kind_reg;
        err_next       = err_reg;
        data_next      = data_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        if (cmd.load_single)
        begin
            out_valid_next = 1'b1;
            err_next       = line_err;
            data_next      = 8'd0;
            last_next      = 1'b1;
            addr_next      = 32'd0;
            if (line_err != ERR_NONE)
            begin
                kind_next = KIND_BAD;
            end
            else if (rec_type == REC_EOF)
            begin
                kind_next = KIND_EOF;
            end
            else
            begin
                kind_next = KIND_EMPTY;
                addr_next = base_comb;
            end
        end
        else if (cmd.load_overlong)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_BAD;
            err_next       = ERR_TOO_LONG;
            data_next      = 8'd0;
            addr_next      = 32'd0;
            last_next      = 1'b1;
        end
        else if (cmd.load_byte)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_DATA;
            err_next       = ERR_NONE;
            data_next      = ram_rdata;
            addr_next      = base_reg + 32'(idx_reg);
            last_next      = status.idx_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg    <= '0;
            colon_seen_reg    <= 1'b0;
            nibble_hold_reg   <= 4'd0;
            header_bytes_reg  <= 32'd0;
            running_sum_reg   <= 8'd0;
            checksum_byte_reg <= 8'd0;
            linear_base_reg   <= 16'd0;
            segment_base_reg  <= 16'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            char_count_reg    <= char_count_next;
            colon_seen_reg    <= colon_seen_next;
            nibble_hold_reg   <= nibble_hold_next;
            header_bytes_reg  <= header_bytes_next;
            running_sum_reg   <= running_sum_next;
            checksum_byte_reg <= checksum_byte_next;
            linear_base_reg   <= linear_base_next;
            segment_base_reg  <= segment_base_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
        kind_reg  <= kind_next;
        err_reg   <= err_next;
        data_reg  <= data_next;
        addr_reg  <= addr_next;
        last_reg  <= last_next;
        if (cmd.cap_base)
        begin
            base_reg <= base_comb;
        end
        if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    ihp_ram #(
        .WIDTH(8),
        .DEPTH(MAX_DATA_BYTES)
    ) u_buffer (
        .clk  (clk),
        .we   (ram_we),
        .waddr(j_idx[IDX_W-1:0]),
        .wdata(byte_val),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign status.is_term  = is_term;
    assign status.cnt_zero = (char_count_reg == '0);
    assign status.overlong = overlong;
    assign status.line_err = (line_err != ERR_NONE);
    assign status.rec_type = rec_type;
    assign status.n_zero   = (rec_count == 8'd0);
    assign status.idx_last = (8'(idx_reg) + 8'd1 == rec_count);
    assign status.out_free = out_free;

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.kind         = kind_reg;
    assign result_ch.error_code   = err_reg;
    assign result_ch.data_byte    = data_reg;
    assign result_ch.byte_address = addr_reg;
    assign result_ch.last         = last_reg;

endmodule

[hw/rtl/ihp_ctrl.sv]
// ----------------------------------------------------------------------------
// Intel HEX record parser controller
// Sequences character collection, the line end decision and the emission
// of data bytes from the buffer.
// ----------------------------------------------------------------------------
module ihp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ihp_pkg::dp_status_t status,
    output ihp_pkg::ctrl_cmd_t  cmd
);
    import ihp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_END  = 3'd1;
    localparam logic [2:0] S_OVER = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_char = 1'b1;
                    if (status.is_term)
                    begin
                        if (!status.cnt_zero)
                        begin
                            state_next = S_END;
                        end
                    end
                    else if (status.overlong)
                    begin
                        state_next = S_OVER;
                    end
                end
            end
            S_END:
            begin
                if (status.out_free)
                begin
                    cmd.clear_count = 1'b1;
                    cmd.cap_base    = 1'b1;
                    cmd.idx_clear   = 1'b1;
                    state_next      = S_IDLE;
                    if (status.line_err)
                    begin
                        cmd.load_single = 1'b1;
                    end
                    else
                    begin
                        case (status.rec_type) inside
                            REC_DATA:
                            begin
                                if (status.n_zero)
                                begin
                                    cmd.load_single = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_RD;
                                end
                            end
                            REC_EOF:
                            begin
                                cmd.load_single = 1'b1;
                            end
                            REC_LINEAR, REC_SEGMENT:
                            begin
                                cmd.set_base = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_OVER:
            begin
                if (status.out_free)
                begin
                    cmd.load_overlong = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (status.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = status.idx_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/ihp_checker.sv]
// ----------------------------------------------------------------------------
// Intel HEX record parser checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ihp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [2:0]  error_code,
    input logic [7:0]  data_byte,
    input logic [31:0] byte_address,
    input logic        last
);
    import ihp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({kind, error_code, data_byte, byte_address, last}))
        else $error("Stalled result changed.");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> data_byte == 8'd0 && last)
        else $error("Non-data result carries a byte or is not last.");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_BAD) == (error_code != ERR_NONE))
        else $error("Error code does not match result kind.");

    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EOF || kind == KIND_BAD) |-> byte_address == 32'd0)
        else $error("End of file or bad line result carries an address.");

endmodule

bind intel_hex_record_parser_unit ihp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .kind        (result_ch.kind),
    .error_code  (result_ch.error_code),
    .data_byte   (result_ch.data_byte),
    .byte_address(result_ch.byte_address),
    .last        (result_ch.last)
);
